/* rtl/mawe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the moving average block.
package mawe_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] WL_RESET = 7'd3;

  localparam int KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_LEAD  = 2'd0;
  localparam kind_t KIND_FULL  = 2'd1;
  localparam kind_t KIND_TRAIL = 2'd2;

  // Shared divider: quotient bits resolved per cycle.
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = DATA_W / DIV_STEPS;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic  last;
    logic  sub_old;
    logic  has_primary;
    kind_t kind;
    logic  short_flag;
  } item_flags_t;

endpackage

/* rtl/moving_average_with_edge_windows.sv */
`timescale 1ns / 1ps
// Top level: moving average with shrinking edge windows over Q16.16 samples.
//
// Channel  Dir  Handshake              Payload
// input    in   in_valid / in_stall    sample, final_sample
// result   out  out_valid / out_stall  mean_value, window_kind, final_result, short_stream
// config   in   cfg_write              cfg_data (window_length)
//
// Steps for a sample that yields a full-window mean: queue pop, old-sample subtract (skipped
// when no old sample leaves the window), add and ring write, the shared divider at 8 quotient
// bits per cycle, output load; a sample that yields none skips the divide. On the last sample
// a setup step, then for each trailing mean one subtract per sample dropped from the tail span
// and a divide, paced by the single ring read port and the shared divider.
// Reset clears counters, sum, queue and output valid; the ring needs no clearing pass.
// A 2-entry queue keeps input accepted while the back part works; results hold under
// out_stall and the back part waits.
module moving_average_with_edge_windows #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [mawe_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mawe_pkg::DATA_W-1:0] sample,
  input  logic                        final_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mawe_pkg::DATA_W-1:0] mean_value,
  output logic [mawe_pkg::KIND_W-1:0] window_kind,
  output logic                        final_result,
  output logic                        short_stream
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CNT1_W = CNT_W + 1;
  localparam int SEEN_W = $clog2(MAX_WINDOW + 2);
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ENT_W  = $bits(mawe_pkg::item_flags_t) + SEEN_W + IDX_W + mawe_pkg::DATA_W;
  localparam int WL_W   = (CNT_W > mawe_pkg::CFG_W) ? CNT_W : mawe_pkg::CFG_W;

  logic [mawe_pkg::CFG_W-1:0] window_length;
  logic [WL_W-1:0]            wl_ext;
  logic [CNT_W-1:0]           w;
  logic [CNT1_W-1:0]          w_inc;
  logic [CNT_W-1:0]           half;

  logic                       q_push;
  logic [ENT_W-1:0]           q_wr_data;
  logic                       q_full;
  logic                       q_pop;
  logic [ENT_W-1:0]           q_rd_data;
  logic                       q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= mawe_pkg::WL_RESET;
    end else if (cfg_write) begin
      window_length <= cfg_data;
    end
  end

  // Clamp the window into 1..MAX_WINDOW.
  assign wl_ext = WL_W'(window_length);
  assign w      = (window_length == '0)          ? CNT_W'(1)
                : (wl_ext > WL_W'(MAX_WINDOW))   ? CNT_W'(MAX_WINDOW)
                : CNT_W'(wl_ext);
  assign w_inc  = CNT1_W'(w) + CNT1_W'(1);
  assign half   = CNT_W'(w_inc >> 1);

  mawe_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .w            (w),
    .half         (half),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .final_sample (final_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  mawe_queue #(
    .WIDTH (ENT_W),
    .DEPTH (mawe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mawe_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .w            (w),
    .half         (half),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_value   (mean_value),
    .window_kind  (window_kind),
    .final_result (final_result),
    .short_stream (short_stream)
  );

endmodule

/* rtl/mawe_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mawe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mawe_queue.sv */
`timescale 1ns / 1ps
// Short register queue between the front and back parts.
module mawe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/mawe_div.sv */
`timescale 1ns / 1ps
// Multi-cycle restoring divider: 32-bit quotient of a window sum by a small count.
module mawe_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 7,
  localparam int EXT_W = mawe_pkg::DATA_W + CNT_W,
  localparam int CC_W = (mawe_pkg::DIV_CYCLES > 1) ? $clog2(mawe_pkg::DIV_CYCLES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        busy,
  output logic [mawe_pkg::DATA_W-1:0] quotient
);

  logic [EXT_W-1:0]            dext;
  logic [CNT_W-1:0]            rem;
  logic [CNT_W-1:0]            dvs;
  logic [CC_W-1:0]             cyc;
  logic [CNT_W-1:0]            rem_next;
  logic [mawe_pkg::DATA_W-1:0] quo_next;

  assign dext = EXT_W'(dividend);

  // The sum is below divisor * 2^32, so the top part starts below the divisor.
  always_comb begin
    logic [CNT_W:0] trial;
    logic           qbit;
    rem_next = rem;
    quo_next = quotient;
    for (int i = 0; i < mawe_pkg::DIV_STEPS; i++) begin
      trial = {rem_next, quo_next[mawe_pkg::DATA_W-1]};
      qbit  = (trial >= {1'b0, dvs});
      if (qbit) begin
        rem_next = CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem_next = trial[CNT_W-1:0];
      end
      quo_next = {quo_next[mawe_pkg::DATA_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem      <= dext[EXT_W-1:mawe_pkg::DATA_W];
      quotient <= dext[mawe_pkg::DATA_W-1:0];
      dvs      <= divisor;
      cyc      <= CC_W'(mawe_pkg::DIV_CYCLES - 1);
      busy     <= 1'b1;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
      if (cyc == '0) begin
        busy <= 1'b0;
      end else begin
        cyc <= cyc - CC_W'(1);
      end
    end
  end

endmodule

/* rtl/mawe_front.sv */
`timescale 1ns / 1ps
// Front part: accepts samples, tracks stream position, classifies each item.
module mawe_front #(
  parameter int MAX_WINDOW = 64,
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int SEEN_W = $clog2(MAX_WINDOW + 2),
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int ENT_W  = $bits(mawe_pkg::item_flags_t) + SEEN_W + IDX_W + mawe_pkg::DATA_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic [CNT_W-1:0]            w,
  input  logic [CNT_W-1:0]            half,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mawe_pkg::DATA_W-1:0] sample,
  input  logic                        final_sample,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [ENT_W-1:0]            q_data
);

  logic [SEEN_W-1:0]     seen;
  logic [IDX_W-1:0]      head;
  logic [SEEN_W-1:0]     seen_next;
  logic [IDX_W-1:0]      head_next;
  logic [SEEN_W-1:0]     w_ext;
  logic [SEEN_W-1:0]     half_ext;
  logic                  accept;
  logic                  lead;
  mawe_pkg::item_flags_t flags;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign w_ext     = SEEN_W'(w);
  assign half_ext  = SEEN_W'(half);
  assign seen_next = (seen == SEEN_W'(MAX_WINDOW + 1)) ? seen : seen + SEEN_W'(1);
  assign head_next = (head == IDX_W'(MAX_WINDOW - 1)) ? '0 : head + IDX_W'(1);
  assign lead      = (seen_next < half_ext);

  always_comb begin
    flags.last        = final_sample;
    flags.sub_old     = (seen >= w_ext);
    flags.has_primary = lead || (seen_next >= w_ext);
    flags.kind        = lead ? mawe_pkg::KIND_LEAD : mawe_pkg::KIND_FULL;
    flags.short_flag  = (seen_next <= w_ext);
  end

  assign q_data = {flags, seen_next, head, sample};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      seen <= '0;
      head <= '0;
    end else if (accept) begin
      // the last sample ends the stream
      if (final_sample) begin
        seen <= '0;
        head <= '0;
      end else begin
        seen <= seen_next;
        head <= head_next;
      end
    end
  end

endmodule

/* rtl/mawe_back.sv */
`timescale 1ns / 1ps
// Back part: keeps the sample ring and window sum, divides, emits results.
module mawe_back #(
  parameter int MAX_WINDOW = 64,
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int SEEN_W = $clog2(MAX_WINDOW + 2),
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int AW1    = IDX_W + 1,
  localparam int SUM_W  = mawe_pkg::DATA_W + $clog2(MAX_WINDOW),
  localparam int ENT_W  = $bits(mawe_pkg::item_flags_t) + SEEN_W + IDX_W + mawe_pkg::DATA_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic [CNT_W-1:0]            w,
  input  logic [CNT_W-1:0]            half,
  input  logic                        q_empty,
  input  logic [ENT_W-1:0]            q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mawe_pkg::DATA_W-1:0] mean_value,
  output logic [mawe_pkg::KIND_W-1:0] window_kind,
  output logic                        final_result,
  output logic                        short_stream
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SUB  = 3'd1;
  localparam logic [2:0] B_ADD  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_TSET = 3'd4;
  localparam logic [2:0] B_TCHK = 3'd5;
  localparam logic [2:0] B_TSUB = 3'd6;

  logic [2:0] st;

  mawe_pkg::item_flags_t       q_flags;
  logic [SEEN_W-1:0]           q_seen;
  logic [IDX_W-1:0]            q_slot;
  logic [mawe_pkg::DATA_W-1:0] q_sample;

  mawe_pkg::item_flags_t       ent_flags;
  logic [SEEN_W-1:0]           ent_seen;
  logic [IDX_W-1:0]            ent_slot;
  logic [mawe_pkg::DATA_W-1:0] ent_sample;

  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            tsum;
  logic [SUM_W-1:0]            sum_add;
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            m;
  logic [CNT_W-1:0]            m_init;
  logic [CNT_W-1:0]            span_init;
  logic [CNT_W-1:0]            tail_cnt;
  logic                        drop;
  mawe_pkg::kind_t             res_kind;
  logic                        res_final;

  logic [AW1-1:0]              old_tmp;
  logic [AW1-1:0]              tail_tmp;
  logic [IDX_W-1:0]            old_addr;
  logic [IDX_W-1:0]            tail_addr;

  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [mawe_pkg::DATA_W-1:0] ram_rdata;

  logic                        div_start;
  logic [SUM_W-1:0]            div_dividend;
  logic [CNT_W-1:0]            div_divisor;
  logic                        div_busy;
  logic [mawe_pkg::DATA_W-1:0] div_quotient;
  logic                        out_free;
  logic                        res_load;

  assign {q_flags, q_seen, q_slot, q_sample} = q_data;

  assign q_pop    = (st == B_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign res_load = (st == B_DIV) && !div_busy && out_free;
  assign sum_add  = sum + SUM_W'(ent_sample);
  assign m_init   = half - CNT_W'(1);

  // Samples held in the window sum, and samples the current trailing mean covers.
  assign span_init = (ent_seen >= SEEN_W'(w)) ? w : CNT_W'(ent_seen);
  assign tail_cnt  = (SEEN_W'(m) < ent_seen) ? m : CNT_W'(ent_seen);
  assign drop      = (cnt > tail_cnt);

  // Ring addresses modulo the ring depth.
  assign old_tmp   = AW1'(q_slot) + AW1'(MAX_WINDOW) - AW1'(w);
  assign old_addr  = (old_tmp >= AW1'(MAX_WINDOW)) ? IDX_W'(old_tmp - AW1'(MAX_WINDOW))
                                                    : IDX_W'(old_tmp);
  assign tail_tmp  = AW1'(ent_slot) + AW1'(1) + AW1'(MAX_WINDOW) - AW1'(cnt);
  assign tail_addr = (tail_tmp >= AW1'(MAX_WINDOW)) ? IDX_W'(tail_tmp - AW1'(MAX_WINDOW))
                                                     : IDX_W'(tail_tmp);

  assign ram_we    = (st == B_ADD);
  assign ram_re    = (q_pop && q_flags.sub_old) || ((st == B_TCHK) && drop);
  assign ram_raddr = (st == B_IDLE) ? old_addr : tail_addr;

  assign div_start    = ((st == B_ADD) && ent_flags.has_primary) || ((st == B_TCHK) && !drop);
  assign div_dividend = (st == B_ADD) ? sum_add : tsum;
  assign div_divisor  = (st == B_TCHK) ? tail_cnt
                      : (ent_flags.kind == mawe_pkg::KIND_LEAD) ? CNT_W'(ent_seen) : w;

  mawe_ram #(
    .WIDTH (mawe_pkg::DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ent_slot),
    .wdata (ent_sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mawe_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      sum       <= '0;
    end else begin
      unique case (st)
        B_IDLE: begin
          if (clear) begin
            sum <= '0;
          end
          if (!q_empty) begin
            ent_flags  <= q_flags;
            ent_seen   <= q_seen;
            ent_slot   <= q_slot;
            ent_sample <= q_sample;
            st         <= q_flags.sub_old ? B_SUB : B_ADD;
          end
        end
        B_SUB: begin
          // drop the sample leaving the window
          sum <= sum - SUM_W'(ram_rdata);
          st  <= B_ADD;
        end
        B_ADD: begin
          sum <= sum_add;
          if (ent_flags.has_primary) begin
            res_kind  <= ent_flags.kind;
            res_final <= ent_flags.last && (m_init == '0);
            st        <= B_DIV;
          end else if (ent_flags.last) begin
            st <= B_TSET;
          end else begin
            st <= B_IDLE;
          end
        end
        B_DIV: begin
          if (res_load) begin
            mean_value   <= div_quotient;
            window_kind  <= res_kind;
            final_result <= res_final;
            short_stream <= ent_flags.last && ent_flags.short_flag;
            if (res_kind == mawe_pkg::KIND_TRAIL) begin
              if (m == CNT_W'(1)) begin
                sum <= '0;
                st  <= B_IDLE;
              end else begin
                m  <= m - CNT_W'(1);
                st <= B_TCHK;
              end
            end else if (ent_flags.last) begin
              st <= B_TSET;
            end else begin
              st <= B_IDLE;
            end
          end
        end
        B_TSET: begin
          tsum <= sum;
          cnt  <= span_init;
          m    <= m_init;
          if (m_init == '0) begin
            sum <= '0;
            st  <= B_IDLE;
          end else begin
            st <= B_TCHK;
          end
        end
        B_TCHK: begin
          // shrink the tail span one sample at a time, then divide
          if (drop) begin
            st <= B_TSUB;
          end else begin
            res_kind  <= mawe_pkg::KIND_TRAIL;
            res_final <= (m == CNT_W'(1));
            st        <= B_DIV;
          end
        end
        B_TSUB: begin
          tsum <= tsum - SUM_W'(ram_rdata);
          cnt  <= cnt - CNT_W'(1);
          st   <= B_TCHK;
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/mawe_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the moving average block, bound to the top level.
module mawe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mawe_pkg::DATA_W-1:0] mean_value,
  input logic [mawe_pkg::KIND_W-1:0] window_kind,
  input logic                        final_result,
  input logic                        short_stream
);

  // A waiting result holds until transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_value) && $stable(window_kind)
      && $stable(final_result) && $stable(short_stream))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // A leading mean is always followed by trailing means on the last sample.
  a_lead_not_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && (window_kind == mawe_pkg::KIND_LEAD) |-> !final_result)
    else $error("leading mean marked as final result");

endmodule

bind moving_average_with_edge_windows mawe_checker u_mawe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .mean_value   (mean_value),
  .window_kind  (window_kind),
  .final_result (final_result),
  .short_stream (short_stream)
);

/* test/moving_average_with_edge_windows_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the moving average block with shrinking edge windows.
module moving_average_with_edge_windows_tb;

  localparam int MAXW       = 64;
  localparam int DW         = mawe_pkg::DATA_W;
  localparam int CFGW       = mawe_pkg::CFG_W;
  localparam int SETTLE_CYC = 100;
  localparam int HOLD_CYC   = 500;
  localparam int LIMIT      = 2000000;

  typedef struct {
    logic [DW-1:0] value;
    logic          last;
  } sample_xfer_t;

  typedef struct {
    logic [DW-1:0]   mean;
    mawe_pkg::kind_t kind;
    logic            fin;
    logic            shrt;
  } mean_rec_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFGW-1:0]             cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [DW-1:0]               sample = '0;
  logic                        final_sample = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [DW-1:0]               mean_value;
  logic [mawe_pkg::KIND_W-1:0] window_kind;
  logic                        final_result;
  logic                        short_stream;

  sample_xfer_t      sample_queue[$];
  mean_rec_t         mean_due[$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                errors = 0;
  int                cycle_count = 0;
  logic              hold_req = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;

  // predictor state
  logic [CFGW-1:0]   win_len = mawe_pkg::WL_RESET;
  logic [DW-1:0]     hist_ring[MAXW];
  logic [63:0]       run_sum = '0;
  int                run_count = 0;
  int                ring_wr = 0;

  moving_average_with_edge_windows #(.MAX_WINDOW(MAXW)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .final_sample(final_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mean_value(mean_value),
    .window_kind(window_kind),
    .final_result(final_result),
    .short_stream(short_stream)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the means one accepted sample causes and queue them.
  task automatic predict_means(input logic [DW-1:0] s, input logic last);
    int w;
    int half;
    int m;
    int c;
    int i;
    logic [63:0] span_sum;
    mean_rec_t step_out[$];
    mean_rec_t r;
    w = int'(win_len);
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    half = (w + 1) / 2;
    if (run_count >= w) run_sum -= hist_ring[(ring_wr + MAXW - w) % MAXW];
    hist_ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % MAXW;
    run_sum += s;
    if (run_count < MAXW + 1) run_count++;
    r.fin = 1'b0;
    r.shrt = 1'b0;
    if (run_count + 1 <= half) begin
      r.mean = DW'(run_sum / 64'(run_count));
      r.kind = mawe_pkg::KIND_LEAD;
      step_out.insert(step_out.size(), r);
    end else if (run_count >= w) begin
      r.mean = DW'(run_sum / 64'(w));
      r.kind = mawe_pkg::KIND_FULL;
      step_out.insert(step_out.size(), r);
    end
    if (last) begin
      for (m = half - 1; m >= 1; m--) begin
        c = (m < run_count) ? m : run_count;
        span_sum = '0;
        for (i = 1; i <= c; i++) span_sum += hist_ring[(ring_wr + MAXW - i) % MAXW];
        r.mean = DW'(span_sum / 64'(c));
        r.kind = mawe_pkg::KIND_TRAIL;
        step_out.insert(step_out.size(), r);
      end
      if (step_out.size() > 0) begin
        foreach (step_out[k]) step_out[k].shrt = (run_count <= w);
        step_out[step_out.size() - 1].fin = 1'b1;
      end
      run_sum = '0;
      run_count = 0;
      ring_wr = 0;
    end
    foreach (step_out[k]) mean_due.insert(mean_due.size(), step_out[k]);
  endtask

  // Sender: offer queued samples, hold while stalled.
  always @(posedge clk) begin : drive
    sample_xfer_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_means(sample, final_sample);
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_queue.pop_front();
          in_valid <= 1'b1;
          sample <= nxt.value;
          final_sample <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYC;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every result transfer against the oldest expected mean.
  always @(posedge clk) begin : check
    mean_rec_t exp_rec;
    if (!rst && out_valid && !out_stall) begin
      if (mean_due.size() == 0) begin
        $error("unexpected result: mean_value %h kind %0d", mean_value, window_kind);
        errors++;
      end else begin
        exp_rec = mean_due.pop_front();
        if (mean_value !== exp_rec.mean) begin
          $error("mean_value: expected %h, got %h", exp_rec.mean, mean_value);
          errors++;
        end
        if (window_kind !== exp_rec.kind) begin
          $error("window_kind: expected %0d, got %0d", exp_rec.kind, window_kind);
          errors++;
        end
        if (final_result !== exp_rec.fin) begin
          $error("final_result: expected %0b, got %0b", exp_rec.fin, final_result);
          errors++;
        end
        if (short_stream !== exp_rec.shrt) begin
          $error("short_stream: expected %0b, got %0b", exp_rec.shrt, short_stream);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [DW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return DW'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_sample(input logic [DW-1:0] v, input logic last);
    sample_xfer_t x;
    x.value = v;
    x.last = last;
    sample_queue.insert(sample_queue.size(), x);
  endtask

  // Drain everything, then let trailing no-result work finish.
  task automatic settle();
    while (sample_queue.size() > 0 || in_valid || mean_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write the window register; this also ends any open stream.
  task automatic write_window(input logic [CFGW-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    win_len = v;
    run_sum = '0;
    run_count = 0;
    ring_wr = 0;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_streams(input logic [CFGW-1:0] wl, input int budget, input int sidle,
                             input int rstall, input bit open_end, input bit pressure);
    int w;
    int len;
    int i;
    bit close;
    settle();
    write_window(wl);
    @(negedge clk);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    w = int'(wl);
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    while (budget > 0) begin
      case ($urandom_range(9))
        0: len = $urandom_range(w, 1);
        1: len = $urandom_range(MAXW + 16, MAXW + 2);
        default: len = $urandom_range(2 * w + 4, 1);
      endcase
      close = 1'b1;
      if (len >= budget) begin
        len = budget;
        close = !open_end;
      end
      for (i = 0; i < len; i++) queue_sample(pick_sample(), close && (i == len - 1));
      budget -= len;
    end
    if (pressure) hold_req = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset window of three: single sample, saturated values, bit patterns
    @(negedge clk);
    queue_sample('1, 1'b1);
    repeat (4) queue_sample('1, 1'b0);
    queue_sample('1, 1'b1);
    queue_sample(32'hAAAA_AAAA, 1'b0);
    queue_sample(32'h5555_5555, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample('1, 1'b1);
    settle();

    // zero length acts as one
    write_window('0);
    @(negedge clk);
    queue_sample(32'h0001_8000, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample('0, 1'b1);
    settle();

    // window of two: final step with nothing to give, then a short stream
    write_window(7'd2);
    @(negedge clk);
    queue_sample($urandom, 1'b1);
    queue_sample($urandom, 1'b0);
    queue_sample($urandom, 1'b1);
    queue_sample($urandom, 1'b0);
    queue_sample($urandom, 1'b0);
    settle();

    // oversize length clamps to the maximum; trailing spans exceed the stream
    write_window('1);
    @(negedge clk);
    for (int i = 0; i < 5; i++) queue_sample(pick_sample(), i == 4);
    settle();

    run_streams(7'd5, 40, 0, 0, 1'b0, 1'b0);
    run_streams(7'd64, 40, 68, 0, 1'b1, 1'b0);
    run_streams(CFGW'($urandom_range(8, 1)), 40, 0, 68, 1'b0, 1'b0);
    run_streams(7'd1, 35, 31, 31, 1'b1, 1'b0);
    run_streams(CFGW'($urandom_range(16, 3)), 45, 31, 31, 1'b0, 1'b1);
    run_streams(7'd64, 90, 0, 0, 1'b0, 1'b0);
    run_streams(7'd100, 35, 31, 31, 1'b0, 1'b0);
    settle();

    if (errors == 0 && mean_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
